@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define LBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also runs during reset.
`define LBM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hdl/lbm_pkg.sv @@
`default_nettype none
package lbm_pkg;

    localparam int NUM_SYMBOLS_DEF = 4;
    localparam int SIDE_DEPTH_DEF  = 16;

    // command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_AMEND = 2'd1;
    localparam logic [1:0] CMD_PULL  = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_FILL   = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_TOP    = 2'd2;

    // one resting order
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] price;
        logic [31:0] vol;
    } t_entry;

    // classified request handed from the front to the engine
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] id;
        logic [31:0] price;
        logic [31:0] qty;
        logic [2:0]  own;     // {symbol, side}
        logic        reject;  // fails the up-front checks of its command
    } t_cmd;

endpackage
`default_nettype wire

@@ hdl/lbm_front.sv @@
`default_nettype none
module lbm_front #(
    parameter int NUM_SYMBOLS = lbm_pkg::NUM_SYMBOLS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [103:0]  i_s_tdata,  // id, symbol index, side, limit price, quantity
    input  wire logic [1:0]    i_s_tuser,  // command
    output logic               o_cmd_valid,
    output lbm_pkg::t_cmd      o_cmd,
    input  wire logic          i_cmd_ready
);

    logic [31:0]   w_id;
    logic [1:0]    w_sym;
    logic          w_side;
    logic [31:0]   w_price;
    logic [31:0]   w_qty;
    logic          w_sym_bad;
    lbm_pkg::t_cmd w_cls;

    lbm_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_n;
    logic          w_push;
    logic          w_pop;

    assign w_id    = i_s_tdata[31:0];
    assign w_sym   = i_s_tdata[33:32];
    assign w_side  = i_s_tdata[34];
    assign w_price = i_s_tdata[66:35];
    assign w_qty   = i_s_tdata[98:67];

    assign w_sym_bad = (32'(w_sym) >= 32'(NUM_SYMBOLS));

    // classify the request
    always_comb begin
        w_cls.cmd   = i_s_tuser;
        w_cls.id    = w_id;
        w_cls.price = w_price;
        w_cls.qty   = w_qty;
        w_cls.own   = {w_sym, w_side};
        unique case (i_s_tuser)
            lbm_pkg::CMD_ADD: begin
                w_cls.reject = (w_id == '0) || (w_price == '0) || (w_qty == '0) || w_sym_bad;
            end
            lbm_pkg::CMD_AMEND: begin
                w_cls.reject = (w_price == '0) || (w_qty == '0);
            end
            lbm_pkg::CMD_PULL: begin
                w_cls.reject = 1'b0;
            end
            default: begin
                w_cls.reject = w_sym_bad;
            end
        endcase
    end

    // two-entry request queue
    assign o_s_tready  = (r_n != 2'd2);
    assign w_push      = i_s_tvalid && o_s_tready;
    assign o_cmd_valid = (r_n != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_n  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_n <= r_n + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cls;
        end
    end

endmodule
`default_nettype wire

@@ hdl/lbm_engine.sv @@
`default_nettype none
module lbm_engine #(
    parameter int NUM_SYMBOLS = lbm_pkg::NUM_SYMBOLS_DEF,
    parameter int SIDE_DEPTH  = lbm_pkg::SIDE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  wire lbm_pkg::t_cmd i_cmd,
    output logic               o_cmd_ready,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [175:0]       o_m_tdata,
    output logic [1:0]         o_m_tuser,
    output logic               o_m_tlast
);

    localparam int NUM_SIDES = 2 * NUM_SYMBOLS;
    localparam int ENTRIES   = NUM_SIDES * SIDE_DEPTH;
    localparam int SW        = $clog2(NUM_SIDES);
    localparam int AW        = $clog2(ENTRIES);
    localparam int CW        = $clog2(SIDE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_FIND, S_FIND_RD, S_FIND_EV, S_DECIDE, S_SHRINK,
        S_RM, S_RM_RD, S_RM_EV, S_ADD_CHK, S_MATCH, S_MATCH_RD, S_MATCH_EV,
        S_FILL, S_INS_START, S_INS, S_INS_RD, S_INS_EV,
        S_TOP, S_TOP_RD, S_TOP_EV, S_TOP_DONE, S_ANSWER, S_STATUS
    } t_state;

    typedef enum logic [1:0] {RET_STATUS, RET_MATCH, RET_READD} t_ret;

    t_state          r_state;
    t_ret            r_ret;
    lbm_pkg::t_cmd   r_cmd;
    logic [SW-1:0]   r_side;
    logic [SW-1:0]   r_own;
    logic [CW-1:0]   r_pos;
    logic [AW-1:0]   r_addr;
    logic [CW-1:0]   r_cnt [NUM_SIDES];
    logic            r_found;
    logic [SW-1:0]   r_fside;
    logic [CW-1:0]   r_fpos;
    lbm_pkg::t_entry r_fent;
    logic [31:0]     r_rem;
    logic            r_ok;
    logic            r_half;
    logic [31:0]     r_tprice;
    logic [35:0]     r_sum;
    logic [31:0]     r_bp;
    logic [35:0]     r_bv;
    logic [31:0]     r_ap;
    logic [35:0]     r_av;
    logic            r_fill_full;
    logic [31:0]     r_fill_id;
    logic [31:0]     r_fill_price;
    logic [31:0]     r_fill_vol;
    logic            r_ovalid;
    logic [175:0]    r_odata;
    logic [1:0]      r_okind;
    logic            r_olast;

    lbm_pkg::t_entry r_mem [ENTRIES];
    lbm_pkg::t_entry r_rdata;

    logic [CW-1:0]   w_cnt;
    logic [AW-1:0]   w_base;
    logic [AW-1:0]   w_addr;
    logic            w_more;
    logic            w_ofree;
    logic            w_emit;
    logic            w_cross;
    logic            w_after;
    logic            w_same;
    lbm_pkg::t_entry w_new;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    lbm_pkg::t_entry w_wdata;

    assign w_cnt   = r_cnt[r_side];
    assign w_base  = AW'(r_side) * AW'(SIDE_DEPTH);
    assign w_addr  = w_base + AW'(r_pos);
    assign w_more  = (({1'b0, r_pos} + 1'b1) < {1'b0, w_cnt});
    assign w_ofree = !r_ovalid || i_m_tready;
    assign w_emit  = w_ofree && ((r_state == S_FILL) || (r_state == S_ANSWER)
                                 || (r_state == S_STATUS));
    assign w_cross = r_own[0] ? (r_rdata.price >= r_cmd.price)
                              : (r_rdata.price <= r_cmd.price);
    assign w_after = r_side[0] ? (r_rdata.price > r_cmd.price)
                               : (r_rdata.price < r_cmd.price);
    assign w_same  = (r_pos == '0) || (r_rdata.price == r_tprice);
    assign w_new   = '{id: r_cmd.id, price: r_cmd.price, vol: r_rem};

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;
    assign o_m_tuser   = r_okind;
    assign o_m_tlast   = r_olast;

    // entry memory write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_addr;
        w_wdata = r_rdata;
        unique case (r_state)
            S_SHRINK: begin
                w_we    = 1'b1;
                w_wdata = '{id: r_cmd.id, price: r_cmd.price, vol: r_cmd.qty};
            end
            S_MATCH_EV: begin
                w_we    = w_cross && (r_rdata.vol > r_rem);
                w_waddr = r_addr;
                w_wdata = '{id: r_rdata.id, price: r_rdata.price, vol: r_rdata.vol - r_rem};
            end
            S_RM_EV: begin
                w_we = 1'b1;
            end
            S_INS: begin
                w_we    = (r_pos == '0);
                w_wdata = w_new;
            end
            S_INS_EV: begin
                w_we    = 1'b1;
                w_wdata = w_after ? r_rdata : w_new;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    // command sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_SIDES; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_ovalid <= w_emit || (r_ovalid && !i_m_tready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_found <= 1'b0;
                        r_pos   <= '0;
                        if (i_cmd.cmd == lbm_pkg::CMD_QUERY) begin
                            r_half <= 1'b0;
                            r_bp   <= '0;
                            r_bv   <= '0;
                            r_ap   <= '0;
                            r_av   <= '0;
                            r_ok   <= !i_cmd.reject;
                            r_side <= SW'({i_cmd.own[2:1], 1'b0});
                            r_state <= i_cmd.reject ? S_ANSWER : S_TOP;
                        end else begin
                            r_ok    <= 1'b0;
                            r_side  <= '0;
                            r_state <= i_cmd.reject ? S_STATUS : S_FIND;
                        end
                    end
                end

                // id search over every side
                S_FIND: begin
                    if (r_pos == w_cnt) begin
                        if (r_side == SW'(NUM_SIDES - 1)) begin
                            r_state <= S_DECIDE;
                        end else begin
                            r_side <= r_side + 1'b1;
                            r_pos  <= '0;
                        end
                    end else begin
                        r_addr  <= w_addr;
                        r_state <= S_FIND_RD;
                    end
                end
                S_FIND_RD: begin
                    r_state <= S_FIND_EV;
                end
                S_FIND_EV: begin
                    if (r_rdata.id == r_cmd.id) begin
                        r_found <= 1'b1;
                        r_fside <= r_side;
                        r_fpos  <= r_pos;
                        r_fent  <= r_rdata;
                        r_state <= S_DECIDE;
                    end else begin
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_FIND;
                    end
                end

                S_DECIDE: begin
                    priority case (r_cmd.cmd)
                        lbm_pkg::CMD_ADD: begin
                            r_own  <= SW'(r_cmd.own);
                            r_side <= SW'(r_cmd.own);
                            r_state <= r_found ? S_STATUS : S_ADD_CHK;
                        end
                        lbm_pkg::CMD_PULL: begin
                            r_side  <= r_fside;
                            r_pos   <= r_fpos;
                            r_ret   <= RET_STATUS;
                            r_ok    <= r_found;
                            r_state <= r_found ? S_RM : S_STATUS;
                        end
                        default: begin
                            r_ok    <= r_found;
                            r_own   <= r_fside;
                            r_side  <= r_fside;
                            r_pos   <= r_fpos;
                            r_ret   <= RET_READD;
                            if (!r_found) begin
                                r_state <= S_STATUS;
                            end else if ((r_cmd.price != r_fent.price)
                                         || (r_cmd.qty > r_fent.vol)) begin
                                r_state <= S_RM;
                            end else begin
                                r_state <= S_SHRINK;
                            end
                        end
                    endcase
                end

                S_SHRINK: begin
                    r_state <= S_STATUS;
                end

                // remove at r_pos: move later entries up one slot
                S_RM: begin
                    if (w_more) begin
                        r_addr  <= w_addr + 1'b1;
                        r_state <= S_RM_RD;
                    end else begin
                        r_cnt[r_side] <= w_cnt - 1'b1;
                        unique case (r_ret)
                            RET_MATCH:  r_state <= S_MATCH;
                            RET_READD:  r_state <= S_ADD_CHK;
                            default:    r_state <= S_STATUS;
                        endcase
                    end
                end
                S_RM_RD: begin
                    r_state <= S_RM_EV;
                end
                S_RM_EV: begin
                    r_pos   <= r_pos + 1'b1;
                    r_state <= S_RM;
                end

                S_ADD_CHK: begin
                    if (w_cnt == CW'(SIDE_DEPTH)) begin
                        r_state <= S_STATUS;
                    end else begin
                        r_ok    <= 1'b1;
                        r_rem   <= r_cmd.qty;
                        r_side  <= r_own ^ SW'(1);
                        r_state <= S_MATCH;
                    end
                end

                // match against the best opposite order
                S_MATCH: begin
                    if ((r_rem == '0) || (w_cnt == '0)) begin
                        r_side  <= r_own;
                        r_state <= (r_rem == '0) ? S_STATUS : S_INS_START;
                    end else begin
                        r_pos   <= '0;
                        r_addr  <= w_base;
                        r_state <= S_MATCH_RD;
                    end
                end
                S_MATCH_RD: begin
                    r_state <= S_MATCH_EV;
                end
                S_MATCH_EV: begin
                    if (!w_cross) begin
                        r_side  <= r_own;
                        r_state <= S_INS_START;
                    end else begin
                        r_fill_id    <= r_rdata.id;
                        r_fill_price <= r_rdata.price;
                        r_ret        <= RET_MATCH;
                        if (r_rdata.vol <= r_rem) begin
                            r_fill_vol  <= r_rdata.vol;
                            r_fill_full <= 1'b1;
                            r_rem       <= r_rem - r_rdata.vol;
                        end else begin
                            r_fill_vol  <= r_rem;
                            r_fill_full <= 1'b0;
                            r_rem       <= '0;
                        end
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (w_ofree) begin
                        r_okind  <= lbm_pkg::KIND_FILL;
                        r_olast  <= 1'b0;
                        r_odata  <= 176'({36'd0, 32'd0, 4'd0, r_fill_vol, r_fill_price,
                                          r_fill_id, 1'b1});
                        r_state  <= r_fill_full ? S_RM : S_MATCH;
                    end
                end

                // insert: scan down from the tail, moving later-priority orders back
                S_INS_START: begin
                    r_pos   <= w_cnt;
                    r_state <= S_INS;
                end
                S_INS: begin
                    if (r_pos == '0) begin
                        r_cnt[r_side] <= w_cnt + 1'b1;
                        r_state       <= S_STATUS;
                    end else begin
                        r_addr  <= w_addr - 1'b1;
                        r_state <= S_INS_RD;
                    end
                end
                S_INS_RD: begin
                    r_state <= S_INS_EV;
                end
                S_INS_EV: begin
                    if (w_after) begin
                        r_pos   <= r_pos - 1'b1;
                        r_state <= S_INS;
                    end else begin
                        r_cnt[r_side] <= w_cnt + 1'b1;
                        r_state       <= S_STATUS;
                    end
                end

                // top of book: sum volume at the best price of one side
                S_TOP: begin
                    r_sum <= '0;
                    if (w_cnt == '0) begin
                        r_tprice <= '0;
                        r_state  <= S_TOP_DONE;
                    end else begin
                        r_pos   <= '0;
                        r_addr  <= w_base;
                        r_state <= S_TOP_RD;
                    end
                end
                S_TOP_RD: begin
                    r_state <= S_TOP_EV;
                end
                S_TOP_EV: begin
                    if (w_same) begin
                        if (r_pos == '0) begin
                            r_tprice <= r_rdata.price;
                        end
                        r_sum <= r_sum + 36'(r_rdata.vol);
                        r_pos <= r_pos + 1'b1;
                        if (w_more) begin
                            r_addr  <= w_addr + 1'b1;
                            r_state <= S_TOP_RD;
                        end else begin
                            r_state <= S_TOP_DONE;
                        end
                    end else begin
                        r_state <= S_TOP_DONE;
                    end
                end
                S_TOP_DONE: begin
                    if (!r_half) begin
                        r_bp    <= r_tprice;
                        r_bv    <= r_sum;
                        r_half  <= 1'b1;
                        r_side  <= r_side + 1'b1;
                        r_state <= S_TOP;
                    end else begin
                        r_ap    <= r_tprice;
                        r_av    <= r_sum;
                        r_state <= S_ANSWER;
                    end
                end

                S_ANSWER: begin
                    if (w_ofree) begin
                        r_okind  <= lbm_pkg::KIND_TOP;
                        r_olast  <= 1'b1;
                        r_odata  <= 176'({r_av, r_ap, r_bv, r_bp, 32'd0, r_ok});
                        r_state  <= S_IDLE;
                    end
                end

                S_STATUS: begin
                    if (w_ofree) begin
                        r_okind  <= lbm_pkg::KIND_STATUS;
                        r_olast  <= 1'b1;
                        r_odata  <= 176'(r_ok);
                        r_state  <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hdl/limit_order_book_matcher.sv @@
// One request at a time through an entry memory with one write and one registered read port.
// Query: reads the orders at the best bid and best ask price of the symbol.
// Add/amend/pull: an id search over every side and its resting orders, then fills,
// entries shifted on remove or insert, and the control and status steps.
// Requests queue two deep ahead of the sequencer; results leave through one register.
// Reset (synchronous, active low) empties the books and queue; entries are not cleared.
`default_nettype none
module limit_order_book_matcher #(
    parameter int NUM_SYMBOLS = lbm_pkg::NUM_SYMBOLS_DEF,
    parameter int SIDE_DEPTH  = lbm_pkg::SIDE_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [103:0] i_s_tdata,  // id, symbol index, side, limit price, quantity
    input  wire logic [1:0]   i_s_tuser,  // command
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [175:0]      o_m_tdata,  // ok, fill id, price, volume,
                                          // ask price, ask volume
    output logic [1:0]        o_m_tuser,  // kind
    output logic              o_m_tlast   // last
);

    logic          w_cmd_valid;
    logic          w_cmd_ready;
    lbm_pkg::t_cmd w_cmd;

    // request intake and classification
    lbm_front #(
        .NUM_SYMBOLS(NUM_SYMBOLS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_cmd_valid(w_cmd_valid),
        .o_cmd      (w_cmd),
        .i_cmd_ready(w_cmd_ready)
    );

    // book engine
    lbm_engine #(
        .NUM_SYMBOLS(NUM_SYMBOLS),
        .SIDE_DEPTH (SIDE_DEPTH)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(w_cmd_valid),
        .i_cmd      (w_cmd),
        .o_cmd_ready(w_cmd_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire

@@ hdl/lbm_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module lbm_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_m_tvalid,
    input wire logic         i_m_tready,
    input wire logic [175:0] o_m_tdata,
    input wire logic [1:0]   o_m_tuser,
    input wire logic         o_m_tlast
);

    // a stalled result holds
    `LBM_ASSERT(a_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "result changed while stalled")

    // fills are accepted and never close a request
    `LBM_ASSERT(a_fill, o_m_tvalid && o_m_tuser == lbm_pkg::KIND_FILL |-> !o_m_tlast && o_m_tdata[0], "bad fill flags")

    // status and query answers always close a request
    `LBM_ASSERT(a_close, o_m_tvalid && o_m_tuser != lbm_pkg::KIND_FILL |-> o_m_tlast, "final result without last")

    // no result kind beyond the top of book answer
    `LBM_ASSERT(a_kind, o_m_tvalid |-> o_m_tuser != 2'd3, "unknown result kind")

endmodule

bind limit_order_book_matcher lbm_checker u_lbm_checker (.*);
`default_nettype wire

@@ tb/tb_limit_order_book_matcher.sv @@
`default_nettype none
module tb_limit_order_book_matcher;

    localparam int NSYM      = lbm_pkg::NUM_SYMBOLS_DEF;
    localparam int DEPTH     = lbm_pkg::SIDE_DEPTH_DEF;
    localparam int NSIDE     = NSYM * 2;
    localparam int N_RANDOM  = 300;
    localparam int MAX_CYC   = 4000000;
    localparam int TAIL_CYC  = 300;

    // one result as it leaves the block
    typedef struct {
        logic [1:0]  kind;
        logic        ok;
        logic [31:0] fid;
        logic [31:0] price;
        logic [35:0] vol;
        logic [31:0] ask_px;
        logic [35:0] ask_vol;
        logic        last;
    } t_book_result;

    // book model and queue of results it expects
    class t_scoreboard;
        logic [31:0]  ord_id    [NSIDE][DEPTH];
        logic [31:0]  ord_price [NSIDE][DEPTH];
        logic [31:0]  ord_vol   [NSIDE][DEPTH];
        int           ord_cnt   [NSIDE];
        t_book_result pending[$];
        int           errors;

        function new();
            errors = 0;
            foreach (ord_cnt[b]) ord_cnt[b] = 0;
        endfunction

        function void push(logic [1:0] kind, logic ok, logic [31:0] fid, logic [31:0] pr,
                           logic [35:0] v, logic [31:0] apr, logic [35:0] av, logic last);
            t_book_result r;
            r.kind = kind; r.ok = ok; r.fid = fid; r.price = pr; r.vol = v;
            r.ask_px = apr; r.ask_vol = av; r.last = last;
            pending = {pending, r};
        endfunction

        function bit locate(logic [31:0] id, output int b, output int p);
            b = 0; p = 0;
            for (int i = 0; i < NSIDE; i++)
                for (int j = 0; j < ord_cnt[i]; j++)
                    if (ord_id[i][j] == id) begin
                        b = i; p = j;
                        return 1;
                    end
            return 0;
        endfunction

        function void drop(int b, int p);
            for (int j = p; j + 1 < ord_cnt[b]; j++) begin
                ord_id[b][j] = ord_id[b][j+1];
                ord_price[b][j] = ord_price[b][j+1];
                ord_vol[b][j] = ord_vol[b][j+1];
            end
            ord_cnt[b]--;
        endfunction

        function void rest(int b, logic [31:0] id, logic [31:0] pr, logic [31:0] v);
            int pos;
            pos = 0;
            while (pos < ord_cnt[b]) begin
                if ((b % 2) ? (ord_price[b][pos] > pr) : (ord_price[b][pos] < pr)) break;
                pos++;
            end
            for (int j = ord_cnt[b]; j > pos; j--) begin
                ord_id[b][j] = ord_id[b][j-1];
                ord_price[b][j] = ord_price[b][j-1];
                ord_vol[b][j] = ord_vol[b][j-1];
            end
            ord_id[b][pos] = id; ord_price[b][pos] = pr; ord_vol[b][pos] = v;
            ord_cnt[b]++;
        endfunction

        // matching add: fills against the opposite side, remainder rests
        function bit place(logic [31:0] id, int sym, int sd, logic [31:0] pr,
                           logic [31:0] v);
            int bk, ps, own, opp;
            logic [31:0] rem;
            if (id == 0 || pr == 0 || v == 0 || sym >= NSYM) return 0;
            if (locate(id, bk, ps)) return 0;
            own = sym * 2 + sd;
            opp = sym * 2 + (sd ^ 1);
            if (ord_cnt[own] >= DEPTH) return 0;
            rem = v;
            while (rem != 0 && ord_cnt[opp] > 0) begin
                if (sd == 0 ? (ord_price[opp][0] > pr) : (ord_price[opp][0] < pr)) break;
                if (ord_vol[opp][0] <= rem) begin
                    push(lbm_pkg::KIND_FILL, 1, ord_id[opp][0], ord_price[opp][0],
                         {4'd0, ord_vol[opp][0]}, 0, 0, 0);
                    rem -= ord_vol[opp][0];
                    drop(opp, 0);
                end else begin
                    push(lbm_pkg::KIND_FILL, 1, ord_id[opp][0], ord_price[opp][0],
                         {4'd0, rem}, 0, 0, 0);
                    ord_vol[opp][0] -= rem;
                    rem = 0;
                end
            end
            if (rem != 0) rest(own, id, pr, rem);
            return 1;
        endfunction

        function void best(int b, output logic [31:0] pr, output logic [35:0] v);
            pr = 0; v = 0;
            if (ord_cnt[b] == 0) return;
            for (int j = 0; j < ord_cnt[b]; j++) begin
                if (ord_price[b][j] != ord_price[b][0]) break;
                v += ord_vol[b][j];
            end
            pr = ord_price[b][0];
        endfunction

        // accepted request: work out its results
        function void note_request(logic [1:0] cmd, logic [31:0] id, int sym, int sd,
                                   logic [31:0] pr, logic [31:0] qty);
            int bk, ps;
            bit ok;
            logic [31:0] bp, ap;
            logic [35:0] bv, av;
            ok = 0;
            case (cmd)
                lbm_pkg::CMD_ADD: ok = place(id, sym, sd, pr, qty);
                lbm_pkg::CMD_AMEND: begin
                    if (pr != 0 && qty != 0 && locate(id, bk, ps)) begin
                        if (pr != ord_price[bk][ps] || qty > ord_vol[bk][ps]) begin
                            drop(bk, ps);
                            void'(place(id, bk / 2, bk % 2, pr, qty));
                        end else begin
                            ord_vol[bk][ps] = qty;
                        end
                        ok = 1;
                    end
                end
                lbm_pkg::CMD_PULL: begin
                    if (locate(id, bk, ps)) begin
                        drop(bk, ps);
                        ok = 1;
                    end
                end
                default: begin
                    bp = 0; bv = 0; ap = 0; av = 0;
                    if (sym < NSYM) begin
                        best(sym * 2, bp, bv);
                        best(sym * 2 + 1, ap, av);
                        ok = 1;
                    end
                    push(lbm_pkg::KIND_TOP, ok, 0, bp, bv, ap, av, 1);
                    return;
                end
            endcase
            push(lbm_pkg::KIND_STATUS, ok, 0, 0, 0, 0, 0, 1);
        endfunction

        function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(t_book_result act);
            t_book_result e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result kind %0d", $time, act.kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("kind", 64'(e.kind), 64'(act.kind));
            cmp("ok", 64'(e.ok), 64'(act.ok));
            cmp("fill id", 64'(e.fid), 64'(act.fid));
            cmp("price", 64'(e.price), 64'(act.price));
            cmp("volume", 64'(e.vol), 64'(act.vol));
            cmp("ask price", 64'(e.ask_px), 64'(act.ask_px));
            cmp("ask volume", 64'(e.ask_vol), 64'(act.ask_vol));
            cmp("last", 64'(e.last), 64'(act.last));
        endfunction
    endclass

    logic           i_clk = 0;
    logic           i_rst_n = 0;
    logic           i_s_tvalid = 0;
    logic           o_s_tready;
    logic [103:0]   i_s_tdata = '0;  // id, symbol index, side, limit price, quantity
    logic [1:0]     i_s_tuser = '0;  // command
    logic           o_m_tvalid;
    logic           i_m_tready = 0;
    logic [175:0]   o_m_tdata;       // ok, fill id, price, volume,
                                     // ask price, ask volume
    logic [1:0]     o_m_tuser;       // kind
    logic           o_m_tlast;

    t_scoreboard sb = new();
    int  n_sent = 0;
    int  cyc = 0;
    bit  stall_done = 0;

    limit_order_book_matcher uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast)
    );

    always #1 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > MAX_CYC) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // offer one request, wait for acceptance
    task automatic send(logic [1:0] cmd, logic [31:0] id, logic [1:0] sym, logic sd,
                        logic [31:0] pr, logic [31:0] qty);
        int gap;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {5'd0, qty, pr, sd, sym, id};
        i_s_tvalid <= 1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(cmd, id, sym, sd, pr, qty);
        n_sent++;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // receiver back-pressure, one long hold-off midway
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!stall_done && n_sent >= 120) begin
                stall_done = 1;
                i_m_tready <= 0;
                repeat (3000) @(negedge i_clk);
            end
            hold = pick_gap();
            if (hold > 0) begin
                i_m_tready <= 0;
                repeat (hold - 1) @(negedge i_clk);
            end else begin
                i_m_tready <= 1;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_book_result r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            r.kind = o_m_tuser;
            r.ok = o_m_tdata[0];
            r.fid = o_m_tdata[32:1];
            r.price = o_m_tdata[64:33];
            r.vol = o_m_tdata[100:65];
            r.ask_px = o_m_tdata[132:101];
            r.ask_vol = o_m_tdata[168:133];
            r.last = o_m_tlast;
            sb.check_result(r);
        end
    end

    function automatic logic [31:0] rnd_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 0;
        if (r < 8) return $urandom();
        return $urandom_range(1, 60);
    endfunction

    function automatic logic [31:0] rnd_price();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 0;
        if (r < 8) return $urandom();
        if (r < 10) return 32'hFFFF_FFFF;
        return 1000 + $urandom_range(0, 12) - 6;
    endfunction

    function automatic logic [31:0] rnd_qty();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 0;
        if (r < 8) return $urandom();
        return $urandom_range(1, 25);
    endfunction

    initial begin
        int r;
        logic [1:0] cmd;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: rejects, match, amend variants, pull, query
        send(lbm_pkg::CMD_ADD,   0,  0, 0, 100, 5);
        send(lbm_pkg::CMD_ADD,   1,  0, 0, 0,   5);
        send(lbm_pkg::CMD_ADD,   1,  0, 0, 100, 0);
        send(lbm_pkg::CMD_ADD,   1,  0, 0, 100, 5);
        send(lbm_pkg::CMD_ADD,   1,  1, 1, 100, 5);
        send(lbm_pkg::CMD_ADD,   2,  0, 0, 100, 7);
        send(lbm_pkg::CMD_QUERY, 0,  0, 0, 0,   0);
        send(lbm_pkg::CMD_ADD,   3,  0, 1, 99,  8);
        send(lbm_pkg::CMD_AMEND, 2,  0, 0, 100, 3);
        send(lbm_pkg::CMD_AMEND, 2,  0, 0, 101, 9);
        send(lbm_pkg::CMD_AMEND, 2,  0, 0, 0,   9);
        send(lbm_pkg::CMD_AMEND, 77, 0, 0, 100, 9);
        send(lbm_pkg::CMD_PULL,  77, 0, 0, 0,   0);
        send(lbm_pkg::CMD_PULL,  2,  0, 0, 0,   0);
        send(lbm_pkg::CMD_ADD,   32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(lbm_pkg::CMD_QUERY, 0,  1, 0, 0,   0);
        send(lbm_pkg::CMD_QUERY, 0,  3, 0, 0,   0);
        // fill one side, one reject on full, then a buy that crosses it
        for (int k = 0; k < DEPTH + 1; k++)
            send(lbm_pkg::CMD_ADD, 1000 + k, 3, 1, 5000 + (k % 5), 32'hF000_0000);
        send(lbm_pkg::CMD_QUERY, 0, 3, 0, 0, 0);
        send(lbm_pkg::CMD_ADD, 2000, 3, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(lbm_pkg::CMD_PULL, 32'hFFFF_FFFF, 0, 0, 0, 0);

        // random traffic, mostly adds on a dense price band
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            cmd = (r < 50) ? lbm_pkg::CMD_ADD : (r < 68) ? lbm_pkg::CMD_AMEND :
                  (r < 83) ? lbm_pkg::CMD_PULL : lbm_pkg::CMD_QUERY;
            send(cmd, rnd_id(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 rnd_price(), rnd_qty());
        end
        i_s_tvalid <= 0;

        wait (sb.pending.size() == 0);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
